// File: hdl/ddw_pkg.sv
package ddw_pkg;

  localparam int VALUE_W       = 27;
  localparam int CMD_W         = 8;
  localparam int DIGIT_W       = 4;
  localparam int POS_W         = 3;
  localparam int DIGIT_COUNT_D = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CMD_W-1:0] CMD_DECODE1 = 8'hC8;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic int max_shown(input int n);
    int m;
    m = 1;
    for (int k = 0; k < n; k++) begin
      m = m * 10;
    end
    return m - 1;
  endfunction

endpackage

// File: hdl/ddw_front.sv
module ddw_front
  import ddw_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_D
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [VALUE_W-1:0]             value,
  input  queue_status_t                  qstat,
  output logic                           push,
  output logic [DIGIT_COUNT*DIGIT_W-1:0] push_digits,
  output logic [POS_W-1:0]               push_pos
);

  localparam int BCD_W = DIGIT_COUNT * DIGIT_W;
  localparam int CNT_W = $clog2(VALUE_W + 1);
  localparam logic [VALUE_W-1:0] MAX_V = VALUE_W'(max_shown(DIGIT_COUNT));
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_W - 1);

  front_state_t       state, state_next;
  logic [VALUE_W-1:0] shreg;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt;
  logic               accept;

  assign accept = start && !busy;

  always_comb begin
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      if (bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (start) state_next = F_CONV;
      end
      F_CONV: begin
        if (cnt == LAST_STEP) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!qstat.full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    push = 1'b0;
    case (state)
      F_IDLE: busy = 1'b0;
      F_CONV: busy = 1'b1;
      F_PUSH: push = !qstat.full;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= (value > MAX_V) ? MAX_V : value;
      bcd   <= '0;
      cnt   <= '0;
    end else if (state == F_CONV) begin
      shreg <= {shreg[VALUE_W-2:0], 1'b0};
      bcd   <= {bcd_adj[BCD_W-2:0], shreg[VALUE_W-1]};
      cnt   <= cnt + 1'b1;
    end
  end

  // first nonzero digit, position 0 is most significant
  always_comb begin
    push_pos = POS_W'(DIGIT_COUNT - 1);
    for (int p = DIGIT_COUNT - 1; p >= 0; p--) begin
      if (bcd[(DIGIT_COUNT-1-p)*DIGIT_W +: DIGIT_W] != '0) push_pos = POS_W'(p);
    end
  end

  assign push_digits = bcd;

endmodule

// File: hdl/ddw_queue.sv
module ddw_queue
  import ddw_pkg::*;
#(
  parameter int ENTRY_W = 35
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               pop,
  output logic [ENTRY_W-1:0] rdata,
  output queue_status_t      qstat
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [AW-1:0]      wptr;
  logic [AW-1:0]      rptr;
  logic [CW-1:0]      count;

  assign qstat.full  = (count == CW'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign rdata       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/ddw_back.sv
module ddw_back
  import ddw_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_D
) (
  input  logic                           clk,
  input  logic                           rst,
  input  queue_status_t                  qstat,
  output logic                           pop,
  input  logic [DIGIT_COUNT*DIGIT_W-1:0] pop_digits,
  input  logic [POS_W-1:0]               pop_pos,
  output logic                           strobe,
  output logic [CMD_W-1:0]               command_byte,
  output logic [DIGIT_W-1:0]             data_byte,
  output logic                           last
);

  localparam int BCD_W = DIGIT_COUNT * DIGIT_W;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);

  back_state_t      state, state_next;
  logic [BCD_W-1:0] digits;
  logic [POS_W-1:0] pos;

  assign last         = (pos == LAST_POS);
  assign command_byte = CMD_DECODE1 | CMD_W'(pos);

  always_comb begin
    data_byte = '0;
    for (int p = 0; p < DIGIT_COUNT; p++) begin
      if (pos == POS_W'(p)) data_byte = digits[(DIGIT_COUNT-1-p)*DIGIT_W +: DIGIT_W];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!qstat.empty) state_next = B_EMIT;
      end
      B_EMIT: begin
        if (last) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    strobe = 1'b0;
    case (state)
      B_IDLE: pop = !qstat.empty;
      B_EMIT: strobe = 1'b1;
      default: strobe = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      digits <= pop_digits;
      pos    <= pop_pos;
    end else if (strobe) begin
      pos    <= pos + 1'b1;
    end
  end

endmodule

// File: hdl/decimal_display_digit_writer.sv
// Converts value (clamped to 10^DIGIT_COUNT-1) to decimal and issues one write per digit
// from the first nonzero digit to the least significant one, one write per cycle on strobe;
// last marks the final write. busy stays high after each accepted item while the bit-serial
// binary-to-BCD converter (one value bit per cycle, 27 steps) runs and until it hands its
// digits to a two-entry queue, a hand-off that waits while the queue is full; the write
// sequencer drains the queue on its own, loading an entry and then issuing its writes, and
// a new value is taken only once the last one is pushed. Results cannot be stalled.
module decimal_display_digit_writer
  import ddw_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_D
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value,
  output logic               strobe,
  output logic [CMD_W-1:0]   command_byte,
  output logic [DIGIT_W-1:0] data_byte,
  output logic               last
);

  localparam int BCD_W   = DIGIT_COUNT * DIGIT_W;
  localparam int ENTRY_W = BCD_W + POS_W;

  queue_status_t    qstat;
  logic             push;
  logic             pop;
  logic [BCD_W-1:0] push_digits;
  logic [POS_W-1:0] push_pos;
  logic [ENTRY_W-1:0] rdata;

  ddw_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .qstat       (qstat),
    .push        (push),
    .push_digits (push_digits),
    .push_pos    (push_pos)
  );

  ddw_queue #(.ENTRY_W(ENTRY_W)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_digits, push_pos}),
    .pop   (pop),
    .rdata (rdata),
    .qstat (qstat)
  );

  ddw_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .pop          (pop),
    .pop_digits   (rdata[ENTRY_W-1:POS_W]),
    .pop_pos      (rdata[POS_W-1:0]),
    .strobe       (strobe),
    .command_byte (command_byte),
    .data_byte    (data_byte),
    .last         (last)
  );

endmodule
